// File: sv/pyuvds_pkg.sv
// shared types and constants for the packed 4:2:0 to planar downscaler
package pyuvds_pkg;

    // configuration port
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE   = 2'd2;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
    localparam logic             SCALE_MODE_RST   = 1'b0;

    // scale modes
    localparam logic MODE_DIV2 = 1'b0;
    localparam logic MODE_DIV4 = 1'b1;

    // payload widths
    localparam int PIXEL_W = 8;
    localparam int SUM_W   = 9;
    localparam int ADDR_W  = 21;

    typedef enum logic [1:0] {
        PLANE_Y,
        PLANE_U,
        PLANE_V
    } plane_t;

    // control that travels with one byte down the output pipeline
    typedef struct packed {
        logic   emit;
        logic   avg;
        logic   chroma_src;
        plane_t plane;
    } item_ctrl_t;

endpackage

// File: sv/pyuvds_ram.sv
// generic single-clock ram, one write port and one registered read port
module pyuvds_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/pyuvds_pos.sv
// frame position counters, pair holds and per-byte decode with line-sum ram access
module pyuvds_pos #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [pyuvds_pkg::PIXEL_W-1:0]      pixel_byte,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      frame_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]     frame_h,
    input  logic [$clog2(MAX_WIDTH*3/2+1)-1:0]  stride,
    input  logic                                scale_mode,
    output pyuvds_pkg::item_ctrl_t              item_ctrl,
    output logic [pyuvds_pkg::SUM_W-1:0]        item_sample,
    output logic [$clog2(MAX_HEIGHT)-1:0]       item_row,
    output logic [$clog2(MAX_WIDTH+1)-1:0]      item_span,
    output logic [$clog2(MAX_WIDTH/2)-1:0]      item_offset,
    output logic                                luma_we,
    output logic [$clog2(MAX_WIDTH/4)-1:0]      luma_addr,
    output logic                                chroma_we,
    output logic [$clog2(MAX_WIDTH/8):0]        chroma_addr,
    output logic [pyuvds_pkg::SUM_W-1:0]        pair_sum
);

    import pyuvds_pkg::*;

    localparam int COL_W   = $clog2(MAX_WIDTH*3/2+1);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int P_W     = $clog2(MAX_WIDTH/2);
    localparam int LA_W    = $clog2(MAX_WIDTH/4);
    localparam int CI_W    = $clog2(MAX_WIDTH/8);

    // byte position inside a pixel pair
    localparam logic [1:0] PH_CHROMA = 2'd0;
    localparam logic [1:0] PH_LUMA0  = 2'd1;
    localparam logic [1:0] PH_LUMA1  = 2'd2;

    logic [COL_W-1:0]   col_reg,   col_next;
    logic [P_W-1:0]     pair_reg,  pair_next;
    logic [1:0]         phase_reg, phase_next;
    logic [ROW_W-1:0]   row_reg,   row_next;
    logic [PIXEL_W-1:0] luma_hold_reg,   luma_hold_next;
    logic [PIXEL_W-1:0] chroma_hold_reg, chroma_hold_next;

    logic [COL_W-1:0] col0;
    logic [COL_W-1:0] col1;
    logic [P_W-1:0]   pair0;
    logic [1:0]       ph0;
    logic [ROW_W:0]   row_inc;
    logic [ROW_W:0]   row_adv;
    logic [ROW_W-1:0] r0;
    logic [SUM_W-1:0] luma_sum;
    logic [SUM_W-1:0] chroma_sum;
    logic             is_luma;
    logic             is_chroma;
    logic             emit;
    logic             luma_wr;
    logic             chroma_wr;

    // position of this byte, with wrap when the frame size shrank
    always_comb
    begin
        col0    = col_reg;
        pair0   = pair_reg;
        ph0     = phase_reg;
        row_inc = {1'b0, row_reg};
        if (col_reg >= stride)
        begin
            col0    = '0;
            pair0   = '0;
            ph0     = PH_CHROMA;
            row_inc = {1'b0, row_reg} + 1'b1;
        end
        r0 = (row_inc >= (ROW_W+1)'(frame_h)) ? '0 : row_inc[ROW_W-1:0];
    end

    // position of the next byte
    always_comb
    begin
        col1       = col0 + 1'b1;
        row_adv    = {1'b0, r0} + 1'b1;
        col_next   = col1;
        pair_next  = pair0;
        phase_next = ph0 + 1'b1;
        row_next   = r0;
        if (col1 >= stride)
        begin
            col_next   = '0;
            pair_next  = '0;
            phase_next = PH_CHROMA;
            row_next   = (row_adv >= (ROW_W+1)'(frame_h)) ? '0 : row_adv[ROW_W-1:0];
        end
        else if (ph0 == PH_LUMA1)
        begin
            pair_next  = pair0 + 1'b1;
            phase_next = PH_CHROMA;
        end
    end

    // decode what this byte does
    always_comb
    begin
        luma_sum         = {1'b0, luma_hold_reg} + {1'b0, pixel_byte};
        chroma_sum       = {1'b0, chroma_hold_reg} + {1'b0, pixel_byte};
        is_luma          = (ph0 == PH_LUMA0) && !r0[0];
        is_chroma        = (ph0 == PH_CHROMA) && !pair0[0];
        emit             = 1'b0;
        luma_wr          = 1'b0;
        chroma_wr        = 1'b0;
        luma_hold_next   = luma_hold_reg;
        chroma_hold_next = chroma_hold_reg;
        item_ctrl        = '0;
        item_sample      = SUM_W'(pixel_byte);
        item_row         = '0;
        item_span        = '0;
        item_offset      = '0;
        pair_sum         = luma_sum;

        if (scale_mode == MODE_DIV2)
        begin
            if (is_luma)
            begin
                emit            = 1'b1;
                item_ctrl.plane = PLANE_Y;
                item_row        = r0 >> 1;
                item_span       = frame_w >> 1;
                item_offset     = pair0;
            end
            else if (is_chroma && !r0[1])
            begin
                emit            = 1'b1;
                item_ctrl.plane = r0[0] ? PLANE_V : PLANE_U;
                item_row        = r0 >> 2;
                item_span       = frame_w >> 2;
                item_offset     = pair0 >> 1;
            end
        end
        else
        begin
            if (is_luma)
            begin
                if (!pair0[0])
                begin
                    luma_hold_next = pixel_byte;
                end
                else if (!r0[1])
                begin
                    // top row of the box: store the pair sum
                    luma_wr = 1'b1;
                end
                else
                begin
                    emit            = 1'b1;
                    item_ctrl.avg   = 1'b1;
                    item_ctrl.plane = PLANE_Y;
                    item_sample     = luma_sum;
                    item_row        = r0 >> 2;
                    item_span       = frame_w >> 2;
                    item_offset     = pair0 >> 1;
                end
            end
            else if (is_chroma && !r0[1])
            begin
                pair_sum = chroma_sum;
                if (!pair0[1])
                begin
                    chroma_hold_next = pixel_byte;
                end
                else if (!r0[2])
                begin
                    chroma_wr = 1'b1;
                end
                else
                begin
                    emit                 = 1'b1;
                    item_ctrl.avg        = 1'b1;
                    item_ctrl.chroma_src = 1'b1;
                    item_ctrl.plane      = r0[0] ? PLANE_V : PLANE_U;
                    item_sample          = chroma_sum;
                    item_row             = r0 >> 3;
                    item_span            = frame_w >> 3;
                    item_offset          = pair0 >> 2;
                end
            end
        end
        item_ctrl.emit = emit & accept;
    end

    // write and read of a line sum share the same index
    assign luma_we     = luma_wr & accept;
    assign chroma_we   = chroma_wr & accept;
    assign luma_addr   = LA_W'(pair0 >> 1);
    assign chroma_addr = {r0[0], CI_W'(pair0 >> 2)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            pair_reg        <= '0;
            phase_reg       <= PH_CHROMA;
            row_reg         <= '0;
            luma_hold_reg   <= '0;
            chroma_hold_reg <= '0;
        end
        else if (accept)
        begin
            col_reg         <= col_next;
            pair_reg        <= pair_next;
            phase_reg       <= phase_next;
            row_reg         <= row_next;
            luma_hold_reg   <= luma_hold_next;
            chroma_hold_reg <= chroma_hold_next;
        end
    end

endmodule

// File: sv/pyuvds_addr.sv
// two-stage back end: box average, row base multiply and plane address
module pyuvds_addr #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]     frame_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]    frame_h,
    input  logic                               scale_mode,
    input  pyuvds_pkg::item_ctrl_t             item_ctrl,
    input  logic [pyuvds_pkg::SUM_W-1:0]       item_sample,
    input  logic [$clog2(MAX_HEIGHT)-1:0]      item_row,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]     item_span,
    input  logic [$clog2(MAX_WIDTH/2)-1:0]     item_offset,
    input  logic [pyuvds_pkg::SUM_W-1:0]       luma_rdata,
    input  logic [pyuvds_pkg::SUM_W-1:0]       chroma_rdata,
    output logic [1:0]                         pending,
    output logic                               push,
    output logic [pyuvds_pkg::ADDR_W-1:0]      push_address,
    output logic [pyuvds_pkg::PIXEL_W-1:0]     push_value
);

    import pyuvds_pkg::*;

    localparam int W_DIM_W = $clog2(MAX_WIDTH+1);
    localparam int H_DIM_W = $clog2(MAX_HEIGHT+1);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int P_W     = $clog2(MAX_WIDTH/2);
    localparam int PROD_W  = ROW_W + W_DIM_W;
    localparam int YS_W    = W_DIM_W + H_DIM_W;

    // luma plane size and chroma plane bases
    logic [W_DIM_W-1:0] ys_w;
    logic [H_DIM_W-1:0] ys_h;
    logic [YS_W-1:0]    ys_reg;
    logic [YS_W:0]      vbase_reg;

    item_ctrl_t         s1_ctrl_reg;
    logic [SUM_W-1:0]   s1_sample_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic [W_DIM_W-1:0] s1_span_reg;
    logic [P_W-1:0]     s1_offset_reg;

    item_ctrl_t         s2_ctrl_reg;
    logic [PIXEL_W-1:0] s2_value_reg;
    logic [PROD_W-1:0]  s2_product_reg;
    logic [P_W-1:0]     s2_offset_reg;

    logic [SUM_W-1:0]   line_sum;
    logic [SUM_W:0]     box_sum;
    logic [PIXEL_W-1:0] s1_value;
    logic [PROD_W-1:0]  s1_product;
    logic [ADDR_W-1:0]  plane_base;

    always_comb
    begin
        if (scale_mode == MODE_DIV4)
        begin
            ys_w = frame_w >> 2;
            ys_h = frame_h >> 2;
        end
        else
        begin
            ys_w = frame_w >> 1;
            ys_h = frame_h >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        ys_reg    <= ys_w * ys_h;
        vbase_reg <= {1'b0, ys_reg} + (YS_W+1)'(ys_reg >> 2);
    end

    // stage one: line sum arrives from ram
    always_comb
    begin
        line_sum   = s1_ctrl_reg.chroma_src ? chroma_rdata : luma_rdata;
        box_sum    = {1'b0, line_sum} + {1'b0, s1_sample_reg};
        s1_value   = s1_ctrl_reg.avg ? box_sum[SUM_W:2] : s1_sample_reg[PIXEL_W-1:0];
        s1_product = s1_row_reg * s1_span_reg;
    end

    // stage two: add plane base and sample offset
    always_comb
    begin
        case (s2_ctrl_reg.plane)
            PLANE_U: plane_base = ADDR_W'(ys_reg);
            PLANE_V: plane_base = ADDR_W'(vbase_reg);
            default: plane_base = '0;
        endcase
        push_address = ADDR_W'(s2_product_reg) + ADDR_W'(s2_offset_reg) + plane_base;
    end

    assign push       = s2_ctrl_reg.emit;
    assign push_value = s2_value_reg;
    assign pending    = {1'b0, s1_ctrl_reg.emit} + {1'b0, s2_ctrl_reg.emit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
        end
        else
        begin
            s1_ctrl_reg <= item_ctrl;
            s2_ctrl_reg <= s1_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sample_reg  <= item_sample;
        s1_row_reg     <= item_row;
        s1_span_reg    <= item_span;
        s1_offset_reg  <= item_offset;
        s2_value_reg   <= s1_value;
        s2_product_reg <= s1_product;
        s2_offset_reg  <= s1_offset_reg;
    end

endmodule

// File: sv/pyuvds_fifo.sv
// small output queue of write beats
module pyuvds_fifo #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [WIDTH-1:0]           out_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = out_valid & out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/packed_yuv420_to_planar_downscaler_unit.sv
// top level of the packed 4:2:0 to planar downscaler
//
//  port group    | dir | handshake             | beat carries
//  --------------+-----+-----------------------+------------------------------
//  pixel in      | in  | in_valid / in_ready   | pixel_byte
//  planar write  | out | out_valid / out_ready | write_address, write_value
//  config        | in  | cfg_write_enable      | cfg_index, cfg_data
//
//  one pixel beat per clock while in_ready is high; a write beat passes back-end
//  stages one and two, then the write queue; each byte reads the line-sum rams
//  and may write them in the accept cycle, data back on the next clock
//  rst_n clears position counters, pair holds, pipeline valids and the queue;
//  line-sum rams are not cleared, every entry is written one box row ahead of use
//  out_ready stalls only the 4-entry write queue; in_ready drops when queued
//  plus in-flight writes would overflow it
module packed_yuv420_to_planar_downscaler_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_enable,
    input  logic [pyuvds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pyuvds_pkg::CFG_W-1:0]       cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [pyuvds_pkg::PIXEL_W-1:0]     pixel_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pyuvds_pkg::ADDR_W-1:0]      write_address,
    output logic [pyuvds_pkg::PIXEL_W-1:0]     write_value
);

    import pyuvds_pkg::*;

    localparam int W_DIM_W     = $clog2(MAX_WIDTH+1);
    localparam int H_DIM_W     = $clog2(MAX_HEIGHT+1);
    localparam int COL_W       = $clog2(MAX_WIDTH*3/2+1);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int P_W         = $clog2(MAX_WIDTH/2);
    localparam int LUMA_DEPTH  = MAX_WIDTH/4;
    localparam int LA_W        = $clog2(LUMA_DEPTH);
    localparam int CA_W        = $clog2(MAX_WIDTH/8) + 1;
    localparam int CHROMA_DEPTH = 2**CA_W;
    localparam int FIFO_DEPTH  = 4;
    localparam int CNT_W       = $clog2(FIFO_DEPTH+1);
    localparam int BEAT_W      = ADDR_W + PIXEL_W;

    // dimension grid and caps
    localparam int W_CAP_I = MAX_WIDTH - MAX_WIDTH % 8;
    localparam int H_CAP_I = MAX_HEIGHT - MAX_HEIGHT % 8;
    localparam logic [CFG_W:0] W_CAP   = W_CAP_I[CFG_W:0];
    localparam logic [CFG_W:0] H_CAP   = H_CAP_I[CFG_W:0];
    localparam logic [CFG_W:0] DIM_MIN = (CFG_W+1)'(8);

    logic [CFG_W-1:0]   frame_width_reg;
    logic [CFG_W-1:0]   frame_height_reg;
    logic               scale_mode_reg;

    logic [CFG_W:0]     w_grid;
    logic [CFG_W:0]     h_grid;
    logic [W_DIM_W-1:0] w_eff;
    logic [H_DIM_W-1:0] h_eff;
    logic [COL_W-1:0]   stride;

    logic               accept;
    item_ctrl_t         item_ctrl;
    logic [SUM_W-1:0]   item_sample;
    logic [ROW_W-1:0]   item_row;
    logic [W_DIM_W-1:0] item_span;
    logic [P_W-1:0]     item_offset;

    logic               luma_we;
    logic [LA_W-1:0]    luma_addr;
    logic [SUM_W-1:0]   luma_rdata;
    logic               chroma_we;
    logic [CA_W-1:0]    chroma_addr;
    logic [SUM_W-1:0]   chroma_rdata;
    logic [SUM_W-1:0]   pair_sum;

    logic [1:0]         pending;
    logic               push;
    logic [ADDR_W-1:0]  push_address;
    logic [PIXEL_W-1:0] push_value;
    logic [BEAT_W-1:0]  out_beat;
    logic [CNT_W-1:0]   fifo_count;
    logic [CNT_W:0]     occupancy;

    // configuration registers, written without handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            scale_mode_reg   <= SCALE_MODE_RST;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_SCALE_MODE:   scale_mode_reg   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // working size: rounded down to a multiple of eight, at least eight, capped
    always_comb
    begin
        w_grid = {1'b0, frame_width_reg[CFG_W-1:3], 3'b000};
        h_grid = {1'b0, frame_height_reg[CFG_W-1:3], 3'b000};
        if (w_grid < DIM_MIN)
        begin
            w_grid = DIM_MIN;
        end
        if (w_grid > W_CAP)
        begin
            w_grid = W_CAP;
        end
        if (h_grid < DIM_MIN)
        begin
            h_grid = DIM_MIN;
        end
        if (h_grid > H_CAP)
        begin
            h_grid = H_CAP;
        end
        w_eff  = W_DIM_W'(w_grid);
        h_eff  = H_DIM_W'(h_grid);
        // bytes per source row: three bytes per pixel pair
        stride = COL_W'(w_eff) + COL_W'(w_eff >> 1);
    end

    // credit against the write queue: queued beats plus beats still in the pipe
    assign occupancy = (CNT_W+1)'(fifo_count) + (CNT_W+1)'(pending);
    assign in_ready  = (occupancy < (CNT_W+1)'(FIFO_DEPTH));
    assign accept    = in_valid & in_ready;

    pyuvds_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel_byte  (pixel_byte),
        .frame_w     (w_eff),
        .frame_h     (h_eff),
        .stride      (stride),
        .scale_mode  (scale_mode_reg),
        .item_ctrl   (item_ctrl),
        .item_sample (item_sample),
        .item_row    (item_row),
        .item_span   (item_span),
        .item_offset (item_offset),
        .luma_we     (luma_we),
        .luma_addr   (luma_addr),
        .chroma_we   (chroma_we),
        .chroma_addr (chroma_addr),
        .pair_sum    (pair_sum)
    );

    // horizontal luma pair sums of the top row of each box
    pyuvds_ram #(
        .WIDTH (SUM_W),
        .DEPTH (LUMA_DEPTH)
    ) u_luma_ram (
        .clk   (clk),
        .we    (luma_we),
        .waddr (luma_addr),
        .wdata (pair_sum),
        .raddr (luma_addr),
        .rdata (luma_rdata)
    );

    // u sums in the lower half, v sums in the upper half
    pyuvds_ram #(
        .WIDTH (SUM_W),
        .DEPTH (CHROMA_DEPTH)
    ) u_chroma_ram (
        .clk   (clk),
        .we    (chroma_we),
        .waddr (chroma_addr),
        .wdata (pair_sum),
        .raddr (chroma_addr),
        .rdata (chroma_rdata)
    );

    pyuvds_addr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_addr (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_w      (w_eff),
        .frame_h      (h_eff),
        .scale_mode   (scale_mode_reg),
        .item_ctrl    (item_ctrl),
        .item_sample  (item_sample),
        .item_row     (item_row),
        .item_span    (item_span),
        .item_offset  (item_offset),
        .luma_rdata   (luma_rdata),
        .chroma_rdata (chroma_rdata),
        .pending      (pending),
        .push         (push),
        .push_address (push_address),
        .push_value   (push_value)
    );

    pyuvds_fifo #(
        .WIDTH (BEAT_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_address, push_value}),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_beat),
        .count     (fifo_count)
    );

    assign write_address = out_beat[BEAT_W-1:PIXEL_W];
    assign write_value   = out_beat[PIXEL_W-1:0];

endmodule
